/* hw/rtl/wsfr_pkg.sv */
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types and constants shared by the frame receiver: parse phases, result
// kinds and header field masks.
// ----------------------------------------------------------------------------
package wsfr_pkg;

   typedef logic [2:0] phase_type;
   typedef logic [1:0] kind_type;

   // parse phases
   localparam phase_type PH_HDR0    = 3'd0;
   localparam phase_type PH_HDR1    = 3'd1;
   localparam phase_type PH_EXTLEN  = 3'd2;
   localparam phase_type PH_KEY     = 3'd3;
   localparam phase_type PH_PAYLOAD = 3'd4;
   localparam phase_type PH_CLOSED  = 3'd5;

   // result kinds
   localparam kind_type KIND_PAYLOAD = 2'd0;
   localparam kind_type KIND_EOM     = 2'd1;
   localparam kind_type KIND_CLOSE   = 2'd2;

   // header fields
   localparam logic [7:0] FIN_BIT       = 8'h80;
   localparam logic [7:0] MASK_BIT      = 8'h80;
   localparam logic [3:0] OPCODE_CLOSE  = 4'h8;
   localparam logic [6:0] LEN7_EXT16    = 7'd126;
   localparam logic [6:0] LEN7_EXT64    = 7'd127;
   localparam logic [3:0] EXT16_BYTES   = 4'd2;
   localparam logic [3:0] EXT64_BYTES   = 4'd8;
   localparam logic [3:0] KEY_BYTES     = 4'd4;

endpackage

/* hw/rtl/websocket_frame_receiver.sv */
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Receive-side frame parser: header, length extension, mask key, unmasking.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries the connection stream one byte per transfer;
//   req_connection_restart drops the byte and returns the parser to frame
//   start, also leaving the closed state. The rsp_ channel gives zero or one
//   result per input byte: an unmasked payload byte (last mark on the end of
//   a final frame), a bare end of message for an empty final frame, or a
//   close indication, after which all bytes are ignored until restart.
// Throughput and timing:
//   One byte per cycle while no result waits on a stalled rsp_. Each byte
//   updates the parse state in the cycle it is accepted, and its result, if
//   any, shows on rsp_ in the next cycle from the result register. The frame
//   length counter is LENGTH_BITS wide and there is a single result register.
// Reset and stall:
//   Reset clears the parse state and empties the result register. While a
//   result waits and rsp_ready is low, req_ready is low; when rsp_ready is
//   high a new byte is taken in the same cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module websocket_frame_receiver #(
   parameter int LENGTH_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_connection_restart,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last_of_message
);

   localparam int LB = LENGTH_BITS;

   wsfr_pkg::phase_type phase_ff, phase_in;
   logic                final_ff, final_in;
   logic                close_ff, close_in;
   logic                masked_ff, masked_in;
   logic [3:0]          hdr_left_ff, hdr_left_in;
   logic [LB-1:0]       pay_left_ff, pay_left_in;
   logic [31:0]         key_ff, key_in;
   logic [1:0]          key_pos_ff, key_pos_in;

   logic                rsp_valid_ff;
   wsfr_pkg::kind_type  kind_ff, kind_in;
   logic [7:0]          byte_ff, byte_in;
   logic                last_ff, last_in;

   logic                go;
   logic                res_fire;
   logic                len_end;
   logic                hdr_end;
   logic [7:0]          key_byte;
   logic [LB-1:0]       pay_dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign go        = req_valid && req_ready;
   assign pay_dec   = pay_left_ff - {{(LB-1){1'b0}}, 1'b1};

   always_comb begin
      case (key_pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      final_in    = final_ff;
      close_in    = close_ff;
      masked_in   = masked_ff;
      hdr_left_in = hdr_left_ff;
      pay_left_in = pay_left_ff;
      key_in      = key_ff;
      key_pos_in  = key_pos_ff;
      res_fire    = 1'b0;
      kind_in     = wsfr_pkg::KIND_PAYLOAD;
      byte_in     = 8'h00;
      last_in     = 1'b0;
      len_end     = 1'b0;
      hdr_end     = 1'b0;

      case (phase_ff)
         wsfr_pkg::PH_HDR0: begin
            final_in = |(req_data_byte & wsfr_pkg::FIN_BIT);
            close_in = (req_data_byte[3:0] == wsfr_pkg::OPCODE_CLOSE);
            phase_in = wsfr_pkg::PH_HDR1;
         end
         wsfr_pkg::PH_HDR1: begin
            masked_in   = |(req_data_byte & wsfr_pkg::MASK_BIT);
            pay_left_in = '0;
            if (req_data_byte[6:0] == wsfr_pkg::LEN7_EXT16) begin
               hdr_left_in = wsfr_pkg::EXT16_BYTES;
               phase_in    = wsfr_pkg::PH_EXTLEN;
            end else if (req_data_byte[6:0] == wsfr_pkg::LEN7_EXT64) begin
               hdr_left_in = wsfr_pkg::EXT64_BYTES;
               phase_in    = wsfr_pkg::PH_EXTLEN;
            end else begin
               pay_left_in = {{(LB-7){1'b0}}, req_data_byte[6:0]};
               len_end     = 1'b1;
            end
         end
         wsfr_pkg::PH_EXTLEN: begin
            // saturate when the next shift would push bits out of the counter
            if (|pay_left_ff[LB-1:LB-8]) begin
               pay_left_in = '1;
            end else begin
               pay_left_in = {pay_left_ff[LB-9:0], req_data_byte};
            end
            hdr_left_in = hdr_left_ff - 4'd1;
            len_end     = (hdr_left_in == 4'd0);
         end
         wsfr_pkg::PH_KEY: begin
            key_in      = {key_ff[23:0], req_data_byte};
            hdr_left_in = hdr_left_ff - 4'd1;
            hdr_end     = (hdr_left_in == 4'd0);
         end
         wsfr_pkg::PH_PAYLOAD: begin
            key_pos_in  = key_pos_ff + 2'd1;
            pay_left_in = pay_dec;
            if (close_ff) begin
               if (pay_dec == '0) begin
                  phase_in = wsfr_pkg::PH_CLOSED;
                  res_fire = 1'b1;
                  kind_in  = wsfr_pkg::KIND_CLOSE;
               end
            end else begin
               res_fire = 1'b1;
               byte_in  = req_data_byte ^ (masked_ff ? key_byte : 8'h00);
               if (pay_dec == '0) begin
                  phase_in = wsfr_pkg::PH_HDR0;
                  last_in  = final_ff;
               end
            end
         end
         default: begin
            phase_in = wsfr_pkg::PH_CLOSED;
         end
      endcase

      // length known: fetch the key or finish the header
      if (len_end) begin
         if (masked_in) begin
            hdr_left_in = wsfr_pkg::KEY_BYTES;
            key_in      = '0;
            phase_in    = wsfr_pkg::PH_KEY;
         end else begin
            hdr_end = 1'b1;
         end
      end

      // header complete: start payload or close out an empty frame
      if (hdr_end) begin
         key_pos_in = 2'd0;
         if (pay_left_in != '0) begin
            phase_in = wsfr_pkg::PH_PAYLOAD;
         end else if (close_in) begin
            phase_in = wsfr_pkg::PH_CLOSED;
            res_fire = 1'b1;
            kind_in  = wsfr_pkg::KIND_CLOSE;
         end else begin
            phase_in = wsfr_pkg::PH_HDR0;
            if (final_in) begin
               res_fire = 1'b1;
               kind_in  = wsfr_pkg::KIND_EOM;
               last_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wsfr_pkg::PH_HDR0;
         final_ff    <= 1'b0;
         close_ff    <= 1'b0;
         masked_ff   <= 1'b0;
         hdr_left_ff <= 4'd0;
         pay_left_ff <= '0;
         key_ff      <= '0;
         key_pos_ff  <= 2'd0;
      end else if (go) begin
         if (req_connection_restart) begin
            phase_ff    <= wsfr_pkg::PH_HDR0;
            final_ff    <= 1'b0;
            close_ff    <= 1'b0;
            masked_ff   <= 1'b0;
            hdr_left_ff <= 4'd0;
            pay_left_ff <= '0;
            key_ff      <= '0;
            key_pos_ff  <= 2'd0;
         end else begin
            phase_ff    <= phase_in;
            final_ff    <= final_in;
            close_ff    <= close_in;
            masked_ff   <= masked_in;
            hdr_left_ff <= hdr_left_in;
            pay_left_ff <= pay_left_in;
            key_ff      <= key_in;
            key_pos_ff  <= key_pos_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= go && !req_connection_restart && res_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (go && !req_connection_restart && res_fire) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_payload_byte    = byte_ff;
   assign rsp_last_of_message = last_ff;

   // a restart transfer always returns the parser to frame start
   assert property (@(posedge clock) disable iff (reset)
      go && req_connection_restart |=> phase_ff == wsfr_pkg::PH_HDR0)
      else $error("restart did not return parser to frame start");

   // a pending close result means the parser is in the closed phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == wsfr_pkg::KIND_CLOSE |->
         phase_ff == wsfr_pkg::PH_CLOSED)
      else $error("close result without closed phase");

   // nothing is produced once closed
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsfr_pkg::PH_CLOSED |-> !res_fire)
      else $error("result produced in closed phase");

   // the key position only moves while payload is being consumed
   assert property (@(posedge clock) disable iff (reset)
      go && !req_connection_restart && phase_ff != wsfr_pkg::PH_PAYLOAD &&
         phase_in != wsfr_pkg::PH_PAYLOAD |=> $stable(key_pos_ff) || key_pos_ff == 2'd0)
      else $error("key position moved outside payload");

endmodule

/* bench/tb_websocket_frame_receiver.sv */
// ----------------------------------------------------------------------------
// tb_websocket_frame_receiver
// Self-checking bench for the frame receiver. A scoreboard class tracks the
// parse state of the byte stream and queues the expected results. The stream
// holds directed frames first, then random well-formed frames, cut-off frames
// and noise; cut-off frames, noise and close frames end in a restart. Sender
// gaps and receiver stalls are random in two mixes and off in the third.
// ----------------------------------------------------------------------------
typedef struct packed {
   wsfr_pkg::kind_type kind;
   logic [7:0]         data;
   logic               last;
} frame_result_type;

class frame_scoreboard;
   wsfr_pkg::phase_type stage;
   logic                fin_flag;
   logic                close_flag;
   logic                mask_flag;
   logic [3:0]          hdr_left;
   logic [63:0]         pay_left;
   logic [31:0]         key_word;
   logic [1:0]          key_idx;
   logic [63:0]         len_mask;
   frame_result_type    pending[$];
   int                  errors;
   int                  n_restart;
   int                  n_payload;
   int                  n_eom;
   int                  n_close;

   function new(int length_bits);
      len_mask  = {64{1'b1}} >> (64 - length_bits);
      errors    = 0;
      n_restart = 0;
      n_payload = 0;
      n_eom     = 0;
      n_close   = 0;
      clear_state();
   endfunction

   function void clear_state();
      stage      = wsfr_pkg::PH_HDR0;
      fin_flag   = 1'b0;
      close_flag = 1'b0;
      mask_flag  = 1'b0;
      hdr_left   = '0;
      pay_left   = '0;
      key_word   = '0;
      key_idx    = '0;
   endfunction

   function void add_result(wsfr_pkg::kind_type kind, logic [7:0] data, logic last);
      pending.push_back('{kind: kind, data: data, last: last});
   endfunction

   function void finish_header();
      key_idx = '0;
      if (pay_left != 0) begin
         stage = wsfr_pkg::PH_PAYLOAD;
      end else if (close_flag) begin
         stage = wsfr_pkg::PH_CLOSED;
         add_result(wsfr_pkg::KIND_CLOSE, 8'h00, 1'b0);
      end else begin
         stage = wsfr_pkg::PH_HDR0;
         // an empty non-final frame ends silently
         if (fin_flag) add_result(wsfr_pkg::KIND_EOM, 8'h00, 1'b1);
      end
   endfunction

   function void finish_length();
      if (mask_flag) begin
         hdr_left = wsfr_pkg::KEY_BYTES;
         key_word = '0;
         stage    = wsfr_pkg::PH_KEY;
      end else begin
         finish_header();
      end
   endfunction

   // one accepted input transfer
   function void note_byte(logic [7:0] b, logic restart);
      logic [7:0] kb;
      if (restart) begin
         n_restart++;
         clear_state();
         return;
      end
      case (stage)
         wsfr_pkg::PH_HDR0: begin
            fin_flag   = b[7];
            close_flag = (b[3:0] == wsfr_pkg::OPCODE_CLOSE);
            stage      = wsfr_pkg::PH_HDR1;
         end
         wsfr_pkg::PH_HDR1: begin
            mask_flag = b[7];
            pay_left  = '0;
            if (b[6:0] == wsfr_pkg::LEN7_EXT16) begin
               hdr_left = wsfr_pkg::EXT16_BYTES;
               stage    = wsfr_pkg::PH_EXTLEN;
            end else if (b[6:0] == wsfr_pkg::LEN7_EXT64) begin
               hdr_left = wsfr_pkg::EXT64_BYTES;
               stage    = wsfr_pkg::PH_EXTLEN;
            end else begin
               pay_left = {57'd0, b[6:0]} & len_mask;
               finish_length();
            end
         end
         wsfr_pkg::PH_EXTLEN: begin
            // saturate when the next byte would overflow the counter
            if (pay_left > (len_mask >> 8)) pay_left = len_mask;
            else pay_left = {pay_left[55:0], b};
            hdr_left--;
            if (hdr_left == 0) finish_length();
         end
         wsfr_pkg::PH_KEY: begin
            key_word = {key_word[23:0], b};
            hdr_left--;
            if (hdr_left == 0) finish_header();
         end
         wsfr_pkg::PH_PAYLOAD: begin
            kb       = mask_flag ? key_word[8*(3-key_idx) +: 8] : 8'h00;
            key_idx  = key_idx + 2'd1;
            pay_left = (pay_left - 64'd1) & len_mask;
            if (close_flag) begin
               if (pay_left == 0) begin
                  stage = wsfr_pkg::PH_CLOSED;
                  add_result(wsfr_pkg::KIND_CLOSE, 8'h00, 1'b0);
               end
            end else if (pay_left == 0) begin
               stage = wsfr_pkg::PH_HDR0;
               add_result(wsfr_pkg::KIND_PAYLOAD, b ^ kb, fin_flag);
            end else begin
               add_result(wsfr_pkg::KIND_PAYLOAD, b ^ kb, 1'b0);
            end
         end
         default: stage = wsfr_pkg::PH_CLOSED;
      endcase
   endfunction

   // one accepted result transfer
   function void check_result(wsfr_pkg::kind_type kind, logic [7:0] data, logic last);
      frame_result_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result: kind %0d byte %02h last %0b",
                  $time, kind, data, last);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (kind !== want.kind) begin
         $display("%0t: result_kind expected %0d, actual %0d", $time, want.kind, kind);
         errors++;
      end
      if (data !== want.data) begin
         $display("%0t: payload_byte expected %02h, actual %02h", $time, want.data, data);
         errors++;
      end
      if (last !== want.last) begin
         $display("%0t: last_of_message expected %0b, actual %0b",
                  $time, want.last, last);
         errors++;
      end
      case (want.kind)
         wsfr_pkg::KIND_PAYLOAD: n_payload++;
         wsfr_pkg::KIND_EOM:     n_eom++;
         default:                n_close++;
      endcase
   endfunction
endclass

module tb_websocket_frame_receiver;

   localparam int LEN_BITS = 64;
   // run limit, many times what about 1400 bytes need in the slowest mix
   localparam int CYCLE_LIMIT = 200_000;
   localparam int BYTES_PER_MIX = 400;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_PONG   = 4'hA;

   typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_connection_restart = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_payload_byte;
   logic       rsp_last_of_message;

   frame_scoreboard sb;
   int send_gap_pct = 28;
   int stall_pct = 53;
   int live_bytes = 0;
   int cycle_count = 0;

   websocket_frame_receiver #(.LENGTH_BITS(LEN_BITS)) uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .req_connection_restart (req_connection_restart),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_payload_byte       (rsp_payload_byte),
      .rsp_last_of_message    (rsp_last_of_message)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_result_kind, rsp_payload_byte, rsp_last_of_message);
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] b, input logic rst);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid              <= 1'b1;
      req_data_byte          <= b;
      req_connection_restart <= rst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!rst && sb.stage != wsfr_pkg::PH_CLOSED) live_bytes++;
      sb.note_byte(b, rst);
      @(negedge clock);
   endtask

   // header, length extension, key, then count payload bytes
   task automatic send_frame(input logic [7:0] hdr0, input logic masked,
                             input len_form_type form, input logic [63:0] len,
                             input int count);
      int i;
      send_byte(hdr0, 1'b0);
      case (form)
         LEN_SHORT: send_byte({masked, len[6:0]}, 1'b0);
         LEN_EXT16: begin
            send_byte({masked, wsfr_pkg::LEN7_EXT16}, 1'b0);
            send_byte(len[15:8], 1'b0);
            send_byte(len[7:0], 1'b0);
         end
         default: begin
            send_byte({masked, wsfr_pkg::LEN7_EXT64}, 1'b0);
            for (i = 7; i >= 0; i--) send_byte(len[8*i +: 8], 1'b0);
         end
      endcase
      if (masked) repeat (wsfr_pkg::KEY_BYTES) send_byte(8'($urandom_range(255)), 1'b0);
      repeat (count) send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic send_random_sequence();
      int           pick;
      int           r;
      int           n;
      logic [3:0]   opc;
      logic [7:0]   hdr0;
      logic         msk;
      len_form_type form;
      logic [63:0]  len;
      pick = $urandom_range(99);
      msk  = 1'($urandom_range(1));
      if ($urandom_range(7) == 0) begin
         opc = wsfr_pkg::OPCODE_CLOSE;
      end else begin
         do opc = 4'($urandom_range(15)); while (opc == wsfr_pkg::OPCODE_CLOSE);
      end
      hdr0 = {1'($urandom_range(1)), 3'($urandom_range(7)), opc};
      r = $urandom_range(99);
      if (r < 75) begin
         form = LEN_SHORT;
         len  = ($urandom_range(9) == 0) ? 64'($urandom_range(125))
                                         : 64'($urandom_range(12));
      end else if (r < 93) begin
         form = LEN_EXT16;
         len  = ($urandom_range(5) == 0) ? 64'($urandom_range(300))
                                         : 64'($urandom_range(20));
      end else begin
         form = LEN_EXT64;
         len  = 64'($urandom_range(40));
      end

      if (pick < 75) begin
         send_frame(hdr0, msk, form, len, int'(len));
         if (opc == wsfr_pkg::OPCODE_CLOSE) begin
            // bytes after a close are dropped until restart
            repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)), 1'b0);
            send_byte(8'($urandom_range(255)), 1'b1);
         end
      end else if (pick < 85) begin
         // huge 64-bit length, cut short by a restart
         len = {$urandom, $urandom};
         send_frame(hdr0, msk, LEN_EXT64, len, $urandom_range(8));
         send_byte(8'($urandom_range(255)), 1'b1);
      end else if (pick < 93) begin
         send_frame(hdr0, msk, form, len, $urandom_range(int'(len)));
         send_byte(8'($urandom_range(255)), 1'b1);
      end else begin
         n = $urandom_range(6, 1);
         repeat (n) send_byte(8'($urandom_range(255)), ($urandom_range(4) == 0));
         send_byte(8'($urandom_range(255)), 1'b1);
      end
   endtask

   initial begin
      int mix;
      int target;
      sb = new(LEN_BITS);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // masked final text frame
      send_frame({1'b1, 3'b000, OP_TEXT}, 1'b1, LEN_SHORT, 64'd2, 2);
      // empty non-final frame, then empty final continuation
      send_frame({1'b0, 3'b000, OP_TEXT}, 1'b0, LEN_SHORT, 64'd0, 0);
      send_frame({1'b1, 3'b000, OP_CONT}, 1'b0, LEN_SHORT, 64'd0, 0);
      // control opcode handled as data, reserved bits set
      send_frame({1'b1, 3'b111, OP_PONG}, 1'b0, LEN_SHORT, 64'd1, 1);
      // largest 64-bit length, top bit set
      send_frame({1'b0, 3'b000, OP_BINARY}, 1'b0, LEN_EXT64, {64{1'b1}}, 1);
      send_byte(8'h00, 1'b1);
      // empty close, then an ignored byte
      send_frame({1'b1, 3'b000, wsfr_pkg::OPCODE_CLOSE}, 1'b0, LEN_SHORT, 64'd0, 0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);

      for (mix = 0; mix < 3; mix++) begin
         case (mix)
            0: begin
               send_gap_pct = 28;
               stall_pct    = 53;
            end
            1: begin
               send_gap_pct = 53;
               stall_pct    = 28;
            end
            default: begin
               send_gap_pct = 0;
               stall_pct    = 0;
            end
         endcase
         target = live_bytes + BYTES_PER_MIX;
         while (live_bytes < target) send_random_sequence();
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("stream of %0d live bytes with %0d restarts, three gap/stall mixes",
               live_bytes, sb.n_restart);
      $display("checked %0d payload bytes, %0d end-of-message and %0d close results",
               sb.n_payload, sb.n_eom, sb.n_close);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
